// ===== design/prv_pkg.sv =====
`timescale 1ns / 1ps

package prv_pkg;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] REC_MAGIC   = 32'h4449_5046;
    localparam logic [15:0] REC_VERSION = 16'd1;
    localparam int          HDR_BYTES   = 12;
    localparam logic [3:0]  HDR_LAST    = 4'(HDR_BYTES - 1);

    typedef enum logic [2:0] {
        V_OK        = 3'd0,
        V_NO_LEN    = 3'd1,
        V_BAD_MAGIC = 3'd2,
        V_BAD_VER   = 3'd3,
        V_LEN_MISM  = 3'd4,
        V_TOO_LONG  = 3'd5,
        V_CRC_MISM  = 3'd6
    } verdict_t;

    typedef struct packed {
        logic        vld;
        verdict_t    verdict;
        logic [31:0] crc;
    } res_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] crc;
    } res_data_t;

    typedef struct packed {
        logic [1:0] count;
    } q_stat_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// ===== design/prv_if.sv =====
`timescale 1ns / 1ps

interface prv_byte_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] data_byte;

    modport source (output valid, output start_req, output data_byte, input ready);
    modport sink   (input valid, input start_req, input data_byte, output ready);
endinterface

interface prv_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [31:0] computed_crc;

    modport source (output valid, output verdict, output computed_crc, input ready);
    modport sink   (input valid, input verdict, input computed_crc, output ready);
endinterface

interface prv_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/prv_core.sv =====
`timescale 1ns / 1ps

module prv_core
    import prv_pkg::*;
#(
    parameter int PAGE_BYTES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_acc,
    input  logic        in_start,
    input  logic [7:0]  in_byte,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    output res_t        res,
    output logic        busy
);

    localparam logic [16:0] ROOM = 17'(PAGE_BYTES - HDR_BYTES);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    logic        stg_vld_reg;
    logic        stg_start_reg;
    logic [7:0]  stg_byte_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [31:0] crc_reg, crc_next;
    logic [63:0] hdr_reg, hdr_next;
    logic [31:0] scrc_reg, scrc_next;
    logic [15:0] exp_len_reg;

    phase_t      eff_phase;
    logic [15:0] eff_cnt;
    logic [63:0] eff_hdr;
    logic [31:0] eff_sc;
    logic [3:0]  nib;
    logic [15:0] cnt_inc;
    logic [31:0] crc_upd;
    logic [31:0] crc_fin;
    logic [15:0] hdr_len;
    verdict_t    hdr_verdict;

    assign hdr_len = hdr_reg[63:48];
    assign crc_upd = crc_byte(crc_reg, stg_byte_reg);
    assign crc_fin = crc_upd ^ CRC_ONES;
    assign cnt_inc = cnt_reg + 16'd1;
    assign busy    = stg_vld_reg;

    always_comb
    begin
        if (exp_len_reg == 16'd0)
            hdr_verdict = V_NO_LEN;
        else if (hdr_reg[31:0] != REC_MAGIC)
            hdr_verdict = V_BAD_MAGIC;
        else if (hdr_reg[47:32] != REC_VERSION)
            hdr_verdict = V_BAD_VER;
        else if (hdr_len != exp_len_reg)
            hdr_verdict = V_LEN_MISM;
        else if ({1'b0, hdr_len} > ROOM)
            hdr_verdict = V_TOO_LONG;
        else
            hdr_verdict = V_OK;
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        hdr_next   = hdr_reg;
        scrc_next  = scrc_reg;
        res        = '0;
        eff_phase  = phase_reg;
        eff_cnt    = cnt_reg;
        eff_hdr    = hdr_reg;
        eff_sc     = scrc_reg;
        nib        = cnt_reg[3:0];
        if (stg_vld_reg)
        begin
            if (stg_start_reg)
            begin
                eff_phase = PH_HEADER;
                eff_cnt   = '0;
                eff_hdr   = '0;
                eff_sc    = '0;
                crc_next  = CRC_ONES;
            end
            nib = eff_cnt[3:0];
            case (eff_phase)
                PH_HEADER:
                begin
                    hdr_next   = eff_hdr;
                    scrc_next  = eff_sc;
                    if (!nib[3])
                        hdr_next[{nib[2:0], 3'b000} +: 8] = stg_byte_reg;
                    else
                        scrc_next[{nib[1:0], 3'b000} +: 8] = stg_byte_reg;
                    cnt_next   = eff_cnt + 16'd1;
                    phase_next = PH_HEADER;
                    // header bytes 0..7 are already held when the last byte arrives
                    if (nib == HDR_LAST)
                    begin
                        cnt_next = '0;
                        if (hdr_verdict != V_OK)
                        begin
                            phase_next  = PH_DONE;
                            res.vld     = 1'b1;
                            res.verdict = hdr_verdict;
                            res.crc     = '0;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                            crc_next   = CRC_ONES;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next = crc_upd;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= hdr_len)
                    begin
                        phase_next  = PH_DONE;
                        res.vld     = 1'b1;
                        res.verdict = (crc_fin == scrc_reg) ? V_OK : V_CRC_MISM;
                        res.crc     = crc_fin;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= 1'b0;
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            crc_reg     <= CRC_ONES;
            hdr_reg     <= '0;
            scrc_reg    <= '0;
            exp_len_reg <= '0;
        end
        else
        begin
            stg_vld_reg <= in_acc;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            crc_reg     <= crc_next;
            hdr_reg     <= hdr_next;
            scrc_reg    <= scrc_next;
            if (cfg_we)
                exp_len_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            stg_start_reg <= in_start;
            stg_byte_reg  <= in_byte;
        end
    end

endmodule

// ===== design/prv_out_queue.sv =====
`timescale 1ns / 1ps

module prv_out_queue
    import prv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_t      push,
    input  logic      out_ready,
    output logic      out_valid,
    output res_data_t out_data,
    output q_stat_t   stat
);

    res_data_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid  = (cnt_reg != 2'd0);
    assign out_data   = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign stat.count = cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push.vld} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push.vld)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.vld)
            mem_reg[wr_ptr_reg] <= '{verdict: push.verdict, crc: push.crc};
    end

endmodule

// ===== design/param_record_validator.sv =====
`timescale 1ns / 1ps
// The closing byte is registered in the input stage and its result in the queue.
// Throughput: 1 byte/cycle while results drain; a waiting result halves it, two stop it.
// The byte-wide CRC update and header checks sit between the input stage and the queue.
// Reset (rst_n, async, active low) clears phase, counters, CRC, header, queue and
// expected_length; no clearing pass is needed.
module param_record_validator
    import prv_pkg::*;
#(
    parameter int PAGE_BYTES = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    prv_byte_if.sink     rec,
    prv_res_if.source    res,
    prv_cfg_if.sink      cfg
);

    res_t      core_res;
    logic      busy;
    logic      q_valid;
    res_data_t q_data;
    q_stat_t   q_stat;
    logic      in_acc;
    logic      pop;
    logic      cfg_we;

    assign pop       = res.valid && res.ready;
    // room check: queued results plus the item in the input stage
    assign rec.ready = ({2'b00, busy} + {1'b0, q_stat.count}) <= (3'd1 + {2'b00, pop});
    assign in_acc    = rec.valid && rec.ready;
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    prv_core #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_acc  (in_acc),
        .in_start(rec.start_req),
        .in_byte (rec.data_byte),
        .cfg_we  (cfg_we),
        .cfg_data(cfg.data),
        .res     (core_res),
        .busy    (busy)
    );

    prv_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (core_res),
        .out_ready(res.ready),
        .out_valid(q_valid),
        .out_data (q_data),
        .stat     (q_stat)
    );

    assign res.valid        = q_valid;
    assign res.verdict      = q_data.verdict;
    assign res.computed_crc = q_data.crc;

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= 2'd2)
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        core_res.vld |-> (q_stat.count != 2'd2) || pop)
        else $error("result pushed into full queue");

    a_valid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid == (q_stat.count != 2'd0))
        else $error("output valid disagrees with queue count");

    a_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> busy)
        else $error("accepted byte missing from input stage");

endmodule
